/* src/i2crr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crr_pkg
// Shared types and constants of the I2C register read master.
// ----------------------------------------------------------------------------
package i2crr_pkg;

   typedef logic [6:0] dev_addr_type;
   typedef logic [7:0] byte_type;
   typedef logic [4:0] count_type;

   // Configuration register map (register index)
   localparam int unsigned REG_DEVICE_ADDRESS = 0;

   // Reset value of the target address
   localparam dev_addr_type DEVICE_ADDRESS_RESET = 7'd72;

   // Low bit of the address byte that marks a read
   localparam byte_type READ_BIT = 8'h01;

endpackage

/* src/i2crr_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crr_req_if
// Request channel: one word per bus phase tick.
// ----------------------------------------------------------------------------
interface i2crr_req_if;
   import i2crr_pkg::*;

   logic      valid;
   logic      ready;
   logic      start_request;
   byte_type  reg_pointer;
   count_type byte_count;
   logic      sda_in;

   modport source (
      output valid, start_request, reg_pointer, byte_count, sda_in,
      input  ready
   );

   modport sink (
      input  valid, start_request, reg_pointer, byte_count, sda_in,
      output ready
   );
endinterface

/* src/i2crr_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crr_rsp_if
// Response channel: bus levels and read data for one phase tick.
// ----------------------------------------------------------------------------
interface i2crr_rsp_if;
   import i2crr_pkg::*;

   logic     valid;
   logic     ready;
   logic     scl_level;
   logic     sda_pull_low;
   logic     busy_res;
   byte_type data_byte;
   logic     data_valid;
   logic     last_byte;
   logic     nack_error;
   logic     done_res;

   modport source (
      output valid, scl_level, sda_pull_low, busy_res, data_byte, data_valid,
             last_byte, nack_error, done_res,
      input  ready
   );

   modport sink (
      input  valid, scl_level, sda_pull_low, busy_res, data_byte, data_valid,
             last_byte, nack_error, done_res,
      output ready
   );
endinterface

/* src/i2c_register_read_master_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_read_master_core
// Phase-level I2C master doing a register read with repeated START.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              contents
//  req_ch    in         valid/ready            start, pointer, count, SDA level
//  rsp_ch    out        valid/ready            SCL, SDA pull, status, read data
//  csr       in         APB write/read         device_address at byte 0
//
//  One word in gives one word out; a word is taken every cycle unless a
//  response is stalled. The phase sequencer and the response register
//  update on the same edge, so a new word may enter in the cycle the
//  waiting response is taken. A stalled response holds req_ch.ready low
//  until it is taken.
//  Reset (synchronous) puts the sequencer in idle and the address at 72.
// ----------------------------------------------------------------------------
module i2c_register_read_master_core #(
   parameter int MAX_BYTES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   i2crr_req_if.sink               req_ch,
   i2crr_rsp_if.source             rsp_ch,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [0:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import i2crr_pkg::*;

   localparam int CW = $clog2(MAX_BYTES + 1);

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_REL  = 5'd1,
      PH_ST_HI   = 5'd2,
      PH_ST_COND = 5'd3,
      PH_ST_LOW  = 5'd4,
      PH_TX_LO   = 5'd5,
      PH_TX_HI   = 5'd6,
      PH_AR_LO   = 5'd7,
      PH_AR_HI   = 5'd8,
      PH_RX_LO   = 5'd9,
      PH_RX_HI   = 5'd10,
      PH_AW_LO   = 5'd11,
      PH_AW_HI   = 5'd12,
      PH_SP_LO   = 5'd13,
      PH_SP_HI   = 5'd14,
      PH_SP_REL  = 5'd15
   } phase_type;

   typedef enum logic [1:0] {
      STG_WADDR = 2'd0,
      STG_PTR   = 2'd1,
      STG_RADDR = 2'd2,
      STG_DATA  = 2'd3
   } stage_type;

   // Sequencer state
   phase_type     phase_ff, phase_in, ph;
   stage_type     stage_ff, stage_in;
   logic [2:0]    bit_ff, bit_in;
   logic [CW-1:0] left_ff, left_in, count_sat;
   byte_type      shift_ff, shift_in;
   byte_type      ptr_ff, ptr_in;
   logic          err_ff, err_in;
   dev_addr_type  addr_ff;

   // Response register
   logic          rsp_valid_ff;
   logic          scl_ff, pull_ff, busy_ff, dv_ff, lb_ff, ne_ff, dn_ff;
   byte_type      db_ff;
   logic          scl_in, pull_in, busy_in, dv_in, lb_in, ne_in, dn_in;
   byte_type      db_in;

   logic          req_accept;
   logic          cfg_write;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready &&
                      (paddr == 1'(REG_DEVICE_ADDRESS));
   assign prdata    = (paddr == 1'(REG_DEVICE_ADDRESS)) ?
                      {25'd0, addr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= DEVICE_ADDRESS_RESET;
      end else if (cfg_write) begin
         addr_ff <= pwdata[6:0];
      end
   end

   // Clamp the requested count to 1..MAX_BYTES
   always_comb begin
      if (req_ch.byte_count == '0) begin
         count_sat = CW'(1);
      end else if (int'(req_ch.byte_count) > MAX_BYTES) begin
         count_sat = CW'(MAX_BYTES);
      end else begin
         count_sat = CW'(req_ch.byte_count);
      end
   end

   // Phase sequencer: outputs and next state for one tick
   always_comb begin
      ph       = (phase_ff > PH_SP_REL) ? PH_IDLE : phase_ff;
      phase_in = PH_IDLE;
      stage_in = stage_ff;
      bit_in   = bit_ff;
      left_in  = left_ff;
      shift_in = shift_ff;
      ptr_in   = ptr_ff;
      err_in   = err_ff;
      scl_in   = 1'b0;
      pull_in  = 1'b0;
      busy_in  = 1'b1;
      db_in    = '0;
      dv_in    = 1'b0;
      lb_in    = 1'b0;
      ne_in    = 1'b0;
      dn_in    = 1'b0;

      // Idle: a start request turns this tick into the first START phase
      if (ph == PH_IDLE) begin
         if (req_ch.start_request) begin
            ptr_in   = req_ch.reg_pointer;
            left_in  = count_sat;
            err_in   = 1'b0;
            stage_in = STG_WADDR;
            bit_in   = '0;
            shift_in = '0;
            ph       = PH_ST_REL;
         end else begin
            scl_in  = 1'b1;
            busy_in = 1'b0;
         end
      end

      unique case (ph)
         PH_ST_REL: begin
            phase_in = PH_ST_HI;
         end
         PH_ST_HI: begin
            scl_in   = 1'b1;
            phase_in = PH_ST_COND;
         end
         PH_ST_COND: begin
            scl_in   = 1'b1;
            pull_in  = 1'b1;
            phase_in = PH_ST_LOW;
         end
         PH_ST_LOW: begin
            pull_in  = 1'b1;
            shift_in = {addr_ff, 1'b0} | ((stage_ff == STG_RADDR) ? READ_BIT : '0);
            bit_in   = '0;
            phase_in = PH_TX_LO;
         end
         PH_TX_LO: begin
            pull_in  = !shift_ff[7];
            phase_in = PH_TX_HI;
         end
         PH_TX_HI: begin
            scl_in   = 1'b1;
            pull_in  = !shift_ff[7];
            shift_in = {shift_ff[6:0], 1'b0};
            if (bit_ff == 3'd7) begin
               bit_in   = '0;
               phase_in = PH_AR_LO;
            end else begin
               bit_in   = bit_ff + 3'd1;
               phase_in = PH_TX_LO;
            end
         end
         PH_AR_LO: begin
            phase_in = PH_AR_HI;
         end
         PH_AR_HI: begin
            scl_in = 1'b1;
            // Sample the target's ACK; a NACK drops to STOP
            if (req_ch.sda_in) begin
               err_in   = 1'b1;
               phase_in = PH_SP_LO;
            end else if (stage_ff == STG_WADDR) begin
               stage_in = STG_PTR;
               shift_in = ptr_ff;
               bit_in   = '0;
               phase_in = PH_TX_LO;
            end else if (stage_ff == STG_PTR) begin
               stage_in = STG_RADDR;
               phase_in = PH_ST_REL;
            end else begin
               stage_in = STG_DATA;
               shift_in = '0;
               bit_in   = '0;
               phase_in = PH_RX_LO;
            end
         end
         PH_RX_LO: begin
            phase_in = PH_RX_HI;
         end
         PH_RX_HI: begin
            scl_in   = 1'b1;
            shift_in = {shift_ff[6:0], req_ch.sda_in};
            if (bit_ff == 3'd7) begin
               dv_in    = 1'b1;
               db_in    = shift_in;
               lb_in    = (left_ff <= CW'(1));
               bit_in   = '0;
               phase_in = PH_AW_LO;
            end else begin
               bit_in   = bit_ff + 3'd1;
               phase_in = PH_RX_LO;
            end
         end
         PH_AW_LO: begin
            pull_in  = (left_ff > CW'(1));
            phase_in = PH_AW_HI;
         end
         PH_AW_HI: begin
            scl_in  = 1'b1;
            pull_in = (left_ff > CW'(1));
            if (left_ff > CW'(1)) begin
               left_in  = left_ff - CW'(1);
               phase_in = PH_RX_LO;
            end else begin
               left_in  = '0;
               phase_in = PH_SP_LO;
            end
         end
         PH_SP_LO: begin
            pull_in  = 1'b1;
            phase_in = PH_SP_HI;
         end
         PH_SP_HI: begin
            scl_in   = 1'b1;
            pull_in  = 1'b1;
            phase_in = PH_SP_REL;
         end
         PH_SP_REL: begin
            scl_in   = 1'b1;
            dn_in    = 1'b1;
            ne_in    = err_ff;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance the sequencer and load the response on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         stage_ff     <= STG_WADDR;
         bit_ff       <= '0;
         left_ff      <= '0;
         shift_ff     <= '0;
         ptr_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            stage_ff     <= stage_in;
            bit_ff       <= bit_in;
            left_ff      <= left_in;
            shift_ff     <= shift_in;
            ptr_ff       <= ptr_in;
            err_ff       <= err_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff  <= scl_in;
         pull_ff <= pull_in;
         busy_ff <= busy_in;
         db_ff   <= db_in;
         dv_ff   <= dv_in;
         lb_ff   <= lb_in;
         ne_ff   <= ne_in;
         dn_ff   <= dn_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_level    = scl_ff;
   assign rsp_ch.sda_pull_low = pull_ff;
   assign rsp_ch.busy_res     = busy_ff;
   assign rsp_ch.data_byte    = db_ff;
   assign rsp_ch.data_valid   = dv_ff;
   assign rsp_ch.last_byte    = lb_ff;
   assign rsp_ch.nack_error   = ne_ff;
   assign rsp_ch.done_res     = dn_ff;

endmodule

/* src/i2crr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crr_checker
// Port-level checks of the register read master, bound to the top level.
// ----------------------------------------------------------------------------
module i2crr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic scl_level,
   input logic sda_pull_low,
   input logic busy_res,
   input logic data_valid,
   input logic last_byte,
   input logic nack_error,
   input logic done_res
);

   // No response word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request word yields a response word on the next cycle
   a_one_for_one: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted word produced no response");

   // A stalled response blocks the request side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // Read data is sampled with SCL high and SDA released, inside a transfer
   a_data_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && data_valid) |-> (busy_res && scl_level && !sda_pull_low))
      else $error("data word outside a read sample phase");

   // Error and last-byte marks only ride on their own events
   a_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!nack_error || done_res) && (!last_byte || data_valid)))
      else $error("error or last mark without its event");

endmodule

bind i2c_register_read_master_core i2crr_checker u_i2crr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .scl_level    (rsp_ch.scl_level),
   .sda_pull_low (rsp_ch.sda_pull_low),
   .busy_res     (rsp_ch.busy_res),
   .data_valid   (rsp_ch.data_valid),
   .last_byte    (rsp_ch.last_byte),
   .nack_error   (rsp_ch.nack_error),
   .done_res     (rsp_ch.done_res)
);
